// ===== rtl/olb_pkg.sv =====
// olb_pkg: shared types and constants of the ordered list buffer
// operation and status codes, transfer structs, cell command struct
// no dependencies
`default_nettype none

package olb_pkg;

  // default sizing of the list
  localparam int DEPTH_DEFAULT = 64;
  localparam int WIDTH_DEFAULT = 32;

  // operation codes carried in func
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_EDIT   = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // one command transfer
  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         position;
    logic signed [31:0] data_value;
  } olb_in_t;

  // one result transfer
  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic               found;
    logic [5:0]         found_position;
    logic [6:0]         entry_count;
  } olb_out_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic       apply;
    op_t        op;
    logic [5:0] position;
  } olb_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/olb_cell.sv =====
// olb_cell: one list entry of the shift chain
// takes from its lower or upper neighbor on insert and delete, flags a read or find hit
// depends on olb_pkg
`default_nettype none

module olb_cell #(
  parameter int INDEX = 0,
  parameter int WIDTH = 32,
  parameter int CW    = 7
) (
  input  wire logic               clk,
  input  wire olb_pkg::olb_cmd_t  cmd,
  input  wire logic [CW-1:0]      count,
  input  wire logic [WIDTH-1:0]   word,
  input  wire logic [WIDTH-1:0]   lower,
  input  wire logic [WIDTH-1:0]   upper,
  output logic [WIDTH-1:0]        value,
  output logic                    hit
);
  import olb_pkg::*;

  logic [WIDTH-1:0] value_next;
  logic [31:0]      idx;
  logic [31:0]      pos;
  logic [31:0]      cnt;

  assign idx = 32'(INDEX);
  assign pos = 32'(cmd.position);
  assign cnt = 32'(count);

  // entry update for the list-changing operations
  always_comb begin
    value_next = value;
    if (cmd.apply) begin
      case (cmd.op)
        OP_APPEND: begin
          if (idx == cnt) value_next = word;
        end
        OP_INSERT: begin
          if (idx == pos) value_next = word;
          else if (idx > pos && idx <= cnt) value_next = lower;
        end
        OP_EDIT: begin
          if (idx == pos) value_next = word;
        end
        OP_DELETE: begin
          if (idx >= pos && idx + 32'd1 < cnt) value_next = upper;
        end
        default: begin
          value_next = value;
        end
      endcase
    end
  end

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // positional match for read, value match over filled entries for find
  assign hit = (cmd.op == OP_READ) ? (idx == pos) : (idx < cnt && value == word);

endmodule

`default_nettype wire

// ===== rtl/olb_tree.sv =====
// olb_tree: registered first-hit tree over the cell hit flags
// one level per cycle, lower positions win, carries position and entry value
// depends on olb_pkg
`default_nettype none

module olb_tree #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             leaf_hit [DEPTH],
  input  wire logic [WIDTH-1:0] leaf_val [DEPTH],
  output logic                  root_hit,
  output logic [$clog2(DEPTH)-1:0] root_idx,
  output logic [WIDTH-1:0]      root_val
);
  import olb_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int LEAVES = 1 << AW;
  localparam int NODES  = 2 * LEAVES;

  // heap layout: root at 1, children of n at 2n and 2n+1, leaves from LEAVES
  logic             hit [1:NODES-1];
  logic [AW-1:0]    idx [1:NODES-1];
  logic [WIDTH-1:0] val [1:NODES-1];

  // leaf registers, padding leaves never hit
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < DEPTH) begin : g_real
      always_ff @(posedge clk) begin
        hit[LEAVES+i] <= leaf_hit[i];
        val[LEAVES+i] <= leaf_val[i];
        idx[LEAVES+i] <= AW'(i);
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        hit[LEAVES+i] <= 1'b0;
        val[LEAVES+i] <= '0;
        idx[LEAVES+i] <= AW'(i);
      end
    end
  end

  // inner nodes, left child has priority
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    always_ff @(posedge clk) begin
      hit[n] <= hit[2*n] | hit[2*n+1];
      if (hit[2*n]) begin
        idx[n] <= idx[2*n];
        val[n] <= val[2*n];
      end else begin
        idx[n] <= idx[2*n+1];
        val[n] <= val[2*n+1];
      end
    end
  end

  assign root_hit = hit[1];
  assign root_idx = idx[1];
  assign root_val = val[1];

endmodule

`default_nettype wire

// ===== rtl/ordered_list_buffer.sv =====
// ordered_list_buffer: bounded ordered list as a chain of entry cells
// top level: command decode, count, cell chain, first-hit tree, result register
// depends on olb_pkg, olb_cell, olb_tree
//
//  channel   handshake      payload   transfer taken when
//  command   start / busy   din       start high and busy low at the clock edge
//  result    done           dout      done high (one cycle, cannot be held off)
//
// the wait from one command transfer to the next is set by the depth of the registered
// first-hit tree; no new command is taken while busy is high
// done rises as busy falls, with the result register loaded at the same edge; the next command
// is taken in the cycle that done is high
// list edits land in the cells at the command transfer edge, all cells shifting at once
// rst clears the count and the control; entries hold no reset and are undefined until written
`default_nettype none

module ordered_list_buffer #(
  parameter int DEPTH = olb_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = olb_pkg::WIDTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire olb_pkg::olb_in_t  din,
  output logic                   done,
  output olb_pkg::olb_out_t      dout
);
  import olb_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CNTW = $clog2(AW + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t            state;
  logic [CNTW-1:0]   cnt;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic              full;
  logic              modify;
  status_t           status_next;
  status_t           status_q;
  op_t               op_q;
  olb_cmd_t          cmd;
  logic [WIDTH-1:0]  word;
  logic [31:0]       pos;
  logic [31:0]       cnt32;

  logic [WIDTH-1:0]  cell_val [DEPTH];
  logic              cell_hit [DEPTH];
  logic              root_hit;
  logic [AW-1:0]     root_idx;
  logic [WIDTH-1:0]  root_val;
  logic signed [WIDTH-1:0] root_sval;

  assign busy   = (state == S_BUSY);
  assign accept = start && !busy;
  assign pos    = 32'(din.position);
  assign cnt32  = 32'(count);
  assign full   = (count == CW'(DEPTH));
  assign word   = WIDTH'(din.data_value);

  // command decode: status and whether the list changes
  always_comb begin
    status_next = ST_OK;
    modify      = 1'b0;
    count_next  = count;
    case (din.func)
      OP_APPEND: begin
        if (full) status_next = ST_FULL;
        else begin
          modify     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_INSERT: begin
        if (pos > cnt32) status_next = ST_BADPOS;
        else if (full) status_next = ST_FULL;
        else begin
          modify     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_EDIT: begin
        if (pos >= cnt32) status_next = ST_BADPOS;
        else modify = 1'b1;
      end
      OP_DELETE: begin
        if (pos >= cnt32) status_next = ST_BADPOS;
        else begin
          modify     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_READ: begin
        if (pos >= cnt32) status_next = ST_BADPOS;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // broadcast to the chain
  assign cmd.apply    = accept && modify;
  assign cmd.op       = op_t'(din.func);
  assign cmd.position = din.position;

  // chain of entry cells, each wired to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower;
    logic [WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_val[i+1];
    end
    olb_cell #(
      .INDEX (i),
      .WIDTH (WIDTH),
      .CW    (CW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .count (count),
      .word  (word),
      .lower (lower),
      .upper (upper),
      .value (cell_val[i]),
      .hit   (cell_hit[i])
    );
  end

  // first-hit tree over the cells
  olb_tree #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_tree (
    .clk      (clk),
    .leaf_hit (cell_hit),
    .leaf_val (cell_val),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_val (root_val)
  );

  assign root_sval = root_val;

  // sequencer, count and done
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_BUSY;
            cnt   <= '0;
            count <= count_next;
          end
        end
        S_BUSY: begin
          if (cnt == CNTW'(AW)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
      endcase
    end
  end

  // held command fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op_t'(din.func);
      status_q <= status_next;
    end
  end

  // result register, loaded from the tree root at the end of the last busy cycle
  always_ff @(posedge clk) begin
    if (busy && cnt == CNTW'(AW)) begin
      dout.status         <= status_q;
      dout.entry_count    <= 7'(count);
      dout.read_value     <= (op_q == OP_READ && status_q == ST_OK) ? 32'(root_sval) : '0;
      dout.found          <= (op_q == OP_FIND) && root_hit;
      dout.found_position <= (op_q == OP_FIND && root_hit) ? 6'(root_idx) : '0;
    end
  end

`ifndef SYNTHESIS
  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without command in flight");

  // a command transfer always starts the tree wait
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("command transfer did not raise busy");

  // the count never passes the capacity while busy
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(count) <= 32'(DEPTH)))
    else $error("entry count beyond capacity");

  // a match is only reported with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && dout.found) |-> (dout.status == ST_OK))
    else $error("found with failing status");

  // a full refusal leaves the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && dout.status == ST_FULL) |-> (dout.entry_count == 7'(DEPTH)))
    else $error("full status below capacity");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_ordered_list_buffer.sv =====
// tb_ordered_list_buffer: self-checking testbench of the ordered list buffer
// drives list commands through start/busy, checks every done transfer against a list tracker
// depends on olb_pkg and ordered_list_buffer
`default_nettype none

module tb_ordered_list_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import olb_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;

  // func codes the block treats as no operation
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  // mix of operations in the random part
  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_t;

  // tracks the list contents and holds the results still owed by the block
  class list_scoreboard;
    logic signed [31:0] store [LIST_DEPTH];
    int unsigned        count;
    olb_out_t           pending [$];
    int unsigned        commands, results, failures, reported;
    int unsigned        full_refusals, bad_positions, find_hits, spare_ops;

    // work out the result of one command and update the list
    function olb_out_t apply_command(olb_in_t c);
      olb_out_t    r;
      int unsigned i;
      r = '0;
      case (c.func)
        OP_APPEND: begin
          if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
            full_refusals++;
          end else begin
            store[count] = c.data_value;
            count++;
          end
        end
        OP_INSERT: begin
          if (c.position > count) begin
            r.status = ST_BADPOS;
            bad_positions++;
          end else if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
            full_refusals++;
          end else begin
            for (i = count; i > c.position; i--) store[i] = store[i-1];
            store[c.position] = c.data_value;
            count++;
          end
        end
        OP_EDIT: begin
          if (c.position >= count) begin
            r.status = ST_BADPOS;
            bad_positions++;
          end else begin
            store[c.position] = c.data_value;
          end
        end
        OP_DELETE: begin
          if (c.position >= count) begin
            r.status = ST_BADPOS;
            bad_positions++;
          end else begin
            for (i = c.position; i + 1 < count; i++) store[i] = store[i+1];
            count--;
          end
        end
        OP_READ: begin
          if (c.position >= count) begin
            r.status = ST_BADPOS;
            bad_positions++;
          end else begin
            r.read_value = store[c.position];
          end
        end
        OP_FIND: begin
          // lowest matching position wins
          for (i = 0; i < count; i++) begin
            if (store[i] == c.data_value) begin
              r.found = 1'b1;
              r.found_position = 6'(i);
              find_hits++;
              break;
            end
          end
        end
        default: begin
          spare_ops++;
        end
      endcase
      r.entry_count = 7'(count);
      return r;
    endfunction

    // command transfer taken by the block
    function void note_command(olb_in_t c);
      pending.push_back(apply_command(c));
      commands++;
    endfunction

    // result transfer from the block against the oldest expectation
    function void check_result(olb_out_t got);
      olb_out_t want;
      results++;
      if (pending.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("error: result %0d arrived with nothing expected", results);
        end
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found !== want.found || got.found_position !== want.found_position ||
          got.entry_count !== want.entry_count) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("error: result %0d (expected/actual) status %0d/%0d read_value %0d/%0d",
                   results, want.status, got.status, want.read_value, got.read_value);
          $display("       found %0b/%0b found_position %0d/%0d entry_count %0d/%0d",
                   want.found, got.found, want.found_position, got.found_position,
                   want.entry_count, got.entry_count);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  olb_in_t  din;
  logic     done;
  olb_out_t dout;

  list_scoreboard sb = new;

  ordered_list_buffer i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .din   (din),
    .done  (done),
    .dout  (dout)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout: %0d results still owed", sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(dout);
      if (start && !busy) sb.note_command(din);
    end
  end

  function automatic olb_in_t make_command(logic [2:0] f, logic [5:0] p, logic signed [31:0] v);
    olb_in_t c;
    c.func = f;
    c.position = p;
    c.data_value = v;
    return c;
  endfunction

  // as many small values as full-range words, so finds hit, plus the two extremes
  function automatic logic signed [31:0] random_word();
    case ($urandom_range(0, 9))
      0:          return 32'sh7fffffff;
      1:          return 32'sh80000000;
      2, 3, 4, 5: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default:    return $urandom();
    endcase
  endfunction

  // random command, positions mostly inside the filled part
  function automatic olb_in_t random_command(mix_t mix);
    olb_in_t     c;
    int          n;
    int unsigned add_pct, del_pct, r;
    n = int'(sb.count);
    case (mix)
      MIX_GROW:   begin add_pct = 72; del_pct = 5;  end
      MIX_EVEN:   begin add_pct = 30; del_pct = 20; end
      default:    begin add_pct = 12; del_pct = 55; end
    endcase
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3)
      c.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    else if (r < add_pct)
      c.func = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
    else if (r < add_pct + del_pct)
      c.func = OP_DELETE;
    else
      case ($urandom_range(0, 2))
        0:       c.func = OP_EDIT;
        1:       c.func = OP_READ;
        default: c.func = OP_FIND;
      endcase
    if ($urandom_range(0, 99) < 12)
      c.position = 6'($urandom_range(0, 63));
    else if (c.func == OP_INSERT)
      c.position = (n > 63) ? 6'd63 : 6'($urandom_range(0, n));
    else
      c.position = (n > 0) ? 6'($urandom_range(0, n - 1)) : 6'd0;
    if (c.func == OP_FIND && n > 0 && $urandom_range(0, 99) < 60)
      c.data_value = sb.store[$urandom_range(0, n - 1)];
    else
      c.data_value = random_word();
    return c;
  endfunction

  // present one command from the current falling edge until it is taken
  task automatic send(input olb_in_t c);
    start <= 1'b1;
    din   <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold start low for a number of cycles
  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // random phase: weighted toward growth, then even, then toward shrinking
  task automatic run_phase(input int unsigned gap_pct, input int unsigned items);
    mix_t mix;
    for (int unsigned i = 0; i < items; i++) begin
      mix = (i < items * 42 / 100) ? MIX_GROW :
            (i < items * 60 / 100) ? MIX_EVEN : MIX_SHRINK;
      if ($urandom_range(0, 99) < gap_pct) pause($urandom_range(1, 10));
      send(random_command(mix));
    end
  endtask

  initial begin
    olb_in_t directed [$];
    rst   = 1'b1;
    start = 1'b0;
    din   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty list errors, extremes, shifts, finds, spare codes
    directed = '{
      make_command(OP_READ,   6'd0,  32'sd0),
      make_command(OP_EDIT,   6'd0,  32'sd1),
      make_command(OP_DELETE, 6'd0,  32'sd0),
      make_command(OP_FIND,   6'd0,  32'sd0),
      make_command(OP_INSERT, 6'd1,  32'sd3),
      make_command(OP_INSERT, 6'd0,  32'sd5),
      make_command(OP_APPEND, 6'd63, 32'sh7fffffff),
      make_command(OP_APPEND, 6'd0,  32'sh80000000),
      make_command(OP_INSERT, 6'd3,  -32'sd1),
      make_command(OP_INSERT, 6'd5,  32'sd9),
      make_command(OP_INSERT, 6'd1,  32'sd5),
      make_command(OP_READ,   6'd0,  32'sd0),
      make_command(OP_READ,   6'd2,  32'sd0),
      make_command(OP_READ,   6'd4,  32'sd0),
      make_command(OP_EDIT,   6'd1,  32'sh12345678),
      make_command(OP_READ,   6'd1,  32'sd0),
      make_command(OP_FIND,   6'd0,  32'sd5),
      make_command(OP_FIND,   6'd0,  32'sh80000000),
      make_command(OP_FIND,   6'd0,  32'sd99),
      make_command(FUNC_SPARE_6, 6'd63, -32'sd1),
      make_command(FUNC_SPARE_7, 6'd21, 32'sh2aaaaaaa),
      make_command(OP_DELETE, 6'd0,  32'sd0),
      make_command(OP_READ,   6'd0,  32'sd0),
      make_command(OP_DELETE, 6'd63, 32'sd0),
      make_command(OP_READ,   6'd63, 32'sd0)
    };
    foreach (directed[k]) send(directed[k]);
    drain();

    // sender gaps rarely, then often, then never
    run_phase(14, 264);
    drain();
    run_phase(71, 264);
    drain();
    run_phase(0, 264);
    drain();

    // let any stray done show up
    repeat (20) @(negedge clk);

    $display("covered %0d list commands, %0d results; %0d full refusals, %0d bad positions,",
             sb.commands, sb.results, sb.full_refusals, sb.bad_positions);
    $display("%0d find hits, %0d spare func codes", sb.find_hits, sb.spare_ops);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d results never came", sb.failures, sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ordered_list_buffer.f =====
rtl/olb_pkg.sv
rtl/olb_cell.sv
rtl/olb_tree.sv
rtl/ordered_list_buffer.sv
dv/tb_ordered_list_buffer.sv
